/* rtl/maae_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// maae_pkg
// Shared sizes, instruction codes and controller/datapath interface types for
// the misaligned access and atomic emulator.
// ----------------------------------------------------------------------------
package maae_pkg;

   localparam int MEM_WORDS = 1024;
   localparam int MEM_AW    = $clog2(MEM_WORDS);
   localparam logic [32:0] WIN_BYTES = 33'(4 * MEM_WORDS);
   localparam logic [MEM_AW-1:0] LAST_WORD = MEM_AW'(MEM_WORDS - 1);

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FAULT = 2'd1,
      ST_UNSUP = 2'd2
   } status_type;

   localparam logic [1:0] FUNC_LOAD  = 2'd0;
   localparam logic [1:0] FUNC_STORE = 2'd1;
   localparam logic [1:0] FUNC_ILL   = 2'd2;

   localparam logic [2:0] F3_H  = 3'd1;
   localparam logic [2:0] F3_W  = 3'd2;
   localparam logic [2:0] F3_HU = 3'd5;

   localparam logic [6:0] OPC_AMO = 7'h2F;

   localparam logic [4:0] AMO_ADD  = 5'h00;
   localparam logic [4:0] AMO_SWAP = 5'h01;
   localparam logic [4:0] AMO_XOR  = 5'h04;
   localparam logic [4:0] AMO_OR   = 5'h08;
   localparam logic [4:0] AMO_AND  = 5'h0C;
   localparam logic [4:0] AMO_MIN  = 5'h10;
   localparam logic [4:0] AMO_MAX  = 5'h14;
   localparam logic [4:0] AMO_MINU = 5'h18;
   localparam logic [4:0] AMO_MAXU = 5'h1C;

   typedef struct packed {
      logic clear;
      logic capture;
      logic read;
      logic write_lo;
      logic write_hi;
      logic load_chk;
      logic load_mem;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic need_mem;
      logic mem_write;
      logic write_hi;
   } dp_stat_type;

endpackage
`default_nettype wire

/* rtl/maae_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// maae_dp
// Datapath: request registers, window check, word memory with two read ports,
// load extraction, AMO combine, byte merge and the result register.
// ----------------------------------------------------------------------------
module maae_dp
   import maae_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire dp_cmd_type  cmd,
   output dp_stat_type      stat,
   input  wire logic [1:0]  req_func,
   input  wire logic [31:0] req_instr,
   input  wire logic [31:0] req_addr,
   input  wire logic [31:0] req_src,
   input  wire logic        base_we,
   input  wire logic [31:0] base_wdata,
   output logic [1:0]       rsp_status,
   output logic             rsp_rd_write,
   output logic [4:0]       rsp_rd_index,
   output logic [31:0]      rsp_rd_value
);

   logic [MEM_AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [31:0]       base_ff;
   logic [1:0]        func_ff;
   logic [31:0]       instr_ff, addr_ff, src_ff;
   logic [31:0]       rd0_ff, rd1_ff;
   logic [31:0]       mem [MEM_WORDS];

   logic [2:0]        f3;
   logic [4:0]        f5;
   logic              is_load, is_store, is_amo, len4, sel_ok, range_ok, fault;
   logic [31:0]       off;
   logic [32:0]       end_off;
   logic [1:0]        bsel;
   logic [MEM_AW-1:0] w0, w1;
   logic [63:0]       pair, old64, data64, new64;
   logic [31:0]       old, ld_val, nw, wdata;
   logic [3:0]        bmask4;
   logic [7:0]        mask8;
   status_type        chk_status;

   assign f3 = instr_ff[14:12];
   assign f5 = instr_ff[31:27];

   always_comb begin
      is_load  = 1'b0;
      is_store = 1'b0;
      is_amo   = 1'b0;
      case (func_ff)
         FUNC_LOAD:  is_load  = f3 inside {F3_H, F3_HU, F3_W};
         FUNC_STORE: is_store = f3 inside {F3_H, F3_W};
         FUNC_ILL:   is_amo   = (instr_ff[6:0] == OPC_AMO) && (f3 == F3_W);
         default:    is_load  = 1'b0;
      endcase
   end

   always_comb begin
      case (f5)
         AMO_ADD, AMO_SWAP, AMO_XOR, AMO_OR, AMO_AND,
         AMO_MIN, AMO_MAX, AMO_MINU, AMO_MAXU: sel_ok = 1'b1;
         default:                              sel_ok = 1'b0;
      endcase
   end

   assign len4     = (f3 == F3_W);
   assign off      = addr_ff - {base_ff[31:2], 2'b00};
   assign end_off  = {1'b0, off} + (len4 ? 33'd3 : 33'd1);
   assign range_ok = (end_off < WIN_BYTES);
   assign fault    = !range_ok || (is_amo && (addr_ff[1:0] != 2'b00));
   assign bsel     = off[1:0];
   assign w0       = off[MEM_AW+1:2];
   assign w1       = w0 + MEM_AW'(1);

   always_comb begin
      if (!(is_load || is_store || is_amo)) begin
         chk_status = ST_UNSUP;
      end else if (fault) begin
         chk_status = ST_FAULT;
      end else if (is_amo && !sel_ok) begin
         chk_status = ST_UNSUP;
      end else begin
         chk_status = ST_DONE;
      end
   end

   assign pair   = {rd1_ff, rd0_ff};
   assign old64  = pair >> {bsel, 3'b000};
   assign old    = old64[31:0];

   always_comb begin
      if (!len4) begin
         ld_val = (f3 == F3_H) ? {{16{old[15]}}, old[15:0]} : {16'h0000, old[15:0]};
      end else begin
         ld_val = old;
      end
   end

   always_comb begin
      case (f5)
         AMO_ADD:  nw = src_ff + old;
         AMO_SWAP: nw = src_ff;
         AMO_XOR:  nw = src_ff ^ old;
         AMO_OR:   nw = src_ff | old;
         AMO_AND:  nw = src_ff & old;
         AMO_MIN:  nw = ($signed(src_ff) < $signed(old)) ? src_ff : old;
         AMO_MAX:  nw = ($signed(src_ff) > $signed(old)) ? src_ff : old;
         AMO_MINU: nw = (src_ff < old) ? src_ff : old;
         AMO_MAXU: nw = (src_ff > old) ? src_ff : old;
         default:  nw = src_ff;
      endcase
   end

   assign wdata  = is_amo ? nw : src_ff;
   assign bmask4 = len4 ? 4'hF : 4'h3;
   assign mask8  = 8'({4'h0, bmask4} << bsel);
   assign data64 = {32'h0, wdata} << {bsel, 3'b000};

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         new64[8*i +: 8] = mask8[i] ? data64[8*i +: 8] : pair[8*i +: 8];
      end
   end

   assign stat.clear_last = (clr_cnt_ff == LAST_WORD);
   assign stat.need_mem   = (chk_status == ST_DONE);
   assign stat.mem_write  = is_store || is_amo;
   assign stat.write_hi   = (is_store || is_amo) && (mask8[7:4] != 4'h0);

   assign clr_cnt_in = cmd.clear ? clr_cnt_ff + MEM_AW'(1) : clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         base_ff    <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
         if (base_we) begin
            base_ff <= base_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff  <= req_func;
         instr_ff <= req_instr;
         addr_ff  <= req_addr;
         src_ff   <= req_src;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         mem[clr_cnt_ff] <= '0;
      end else if (cmd.write_lo) begin
         mem[w0] <= new64[31:0];
      end else if (cmd.write_hi) begin
         mem[w1] <= new64[63:32];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd0_ff <= mem[w0];
         rd1_ff <= mem[w1];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_chk) begin
         rsp_status   <= chk_status;
         rsp_rd_write <= 1'b0;
         rsp_rd_index <= '0;
         rsp_rd_value <= '0;
      end else if (cmd.load_mem) begin
         rsp_status   <= ST_DONE;
         rsp_rd_write <= is_load || is_amo;
         rsp_rd_index <= (is_load || is_amo) ? instr_ff[11:7] : 5'd0;
         rsp_rd_value <= is_load ? ld_val : (is_amo ? old : 32'h0);
      end
   end

endmodule
`default_nettype wire

/* rtl/maae_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// maae_ctrl
// Controller: memory clearing pass, request sequencing through check, read,
// write and result load, and the request/result handshakes.
// ----------------------------------------------------------------------------
module maae_ctrl
   import maae_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output dp_cmd_type       cmd,
   input  wire dp_stat_type stat
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_CHECK,
      S_EXEC,
      S_WRHI
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, req_ready_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = req_ready_ff;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      req_ready_in = req_ready_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_last) begin
               state_in     = S_IDLE;
               req_ready_in = 1'b1;
            end
         end
         S_IDLE: begin
            if (req_tvalid && req_ready_ff) begin
               cmd.capture  = 1'b1;
               req_ready_in = 1'b0;
               state_in     = S_CHECK;
            end
         end
         S_CHECK: begin
            if (slot_free) begin
               if (stat.need_mem) begin
                  cmd.read = 1'b1;
                  state_in = S_EXEC;
               end else begin
                  cmd.load_chk = 1'b1;
                  rsp_valid_in = 1'b1;
                  req_ready_in = 1'b1;
                  state_in     = S_IDLE;
               end
            end
         end
         S_EXEC: begin
            cmd.write_lo = stat.mem_write;
            if (stat.write_hi) begin
               state_in = S_WRHI;
            end else begin
               cmd.load_mem = 1'b1;
               rsp_valid_in = 1'b1;
               req_ready_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_WRHI: begin
            cmd.write_hi = 1'b1;
            cmd.load_mem = 1'b1;
            rsp_valid_in = 1'b1;
            req_ready_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in     = S_IDLE;
            req_ready_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         req_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= req_ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/misaligned_and_atomic_access_emulator_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// misaligned_and_atomic_access_emulator_top
// Emulates trapped misaligned loads/stores and word AMOs on an internal
// little-endian word memory mapped at a programmable base address.
//
// After reset the block clears its word memory, one word per cycle, and
// accepts the first request once the last of its MEM_WORDS (1024) words is
// cleared; the base register may be written during that time. One request
// is in flight at a time: a faulting or unsupported request is answered from
// the check, a load, an AMO or a store within one word passes through check
// and one execute state, and a store spanning two words adds a second write
// state, set by the single write port of the memory (read, then one write
// per touched word). A finished result waits in an output register while the next request is accepted.
// ----------------------------------------------------------------------------
module misaligned_and_atomic_access_emulator_top
   import maae_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [95:0] req_tdata,   // instruction, access_addr, store_value
   input  wire logic [1:0]  req_tuser,   // func
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // rd_index, rd_value, zero pad
   output logic [2:0]       rsp_tuser,   // status, rd_write
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_data     // mem_base
);

   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic [1:0]  rsp_status;
   logic        rsp_rd_write;
   logic [4:0]  rsp_rd_index;
   logic [31:0] rsp_rd_value;

   assign csr_ready = 1'b1;
   assign rsp_tdata = {3'b000, rsp_rd_value, rsp_rd_index};
   assign rsp_tuser = {rsp_rd_write, rsp_status};

   maae_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   maae_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_func     (req_tuser),
      .req_instr    (req_tdata[31:0]),
      .req_addr     (req_tdata[63:32]),
      .req_src      (req_tdata[95:64]),
      .base_we      (csr_valid),
      .base_wdata   (csr_data),
      .rsp_status   (rsp_status),
      .rsp_rd_write (rsp_rd_write),
      .rsp_rd_index (rsp_rd_index),
      .rsp_rd_value (rsp_rd_value)
   );

endmodule
`default_nettype wire
